@@ rtl/button_click_hold_detector_macros.svh @@
// ----------------------------------------------------------------------------
// button click hold detector assertion macros
// shared property wrappers for the block's checks
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

// same-cycle implication
`define BCHD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCHD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication
`define BCHD_ASSERT_LAT2(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ rtl/bchd_pkg.sv @@
// ----------------------------------------------------------------------------
// bchd_pkg
// shared types and constants of the button click hold detector
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int PRESS_W  = 16;
  localparam int WINDOW_W = 8;
  localparam int STATUS_W = 3;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OPEN     = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_HELD     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_CLICKED  = 3'd4,
    ST_DOUBLE   = 3'd5
  } btn_state_t;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] REG_DCE    = 2'd0;
  localparam logic [1:0] REG_ALOW   = 2'd1;
  localparam logic [1:0] REG_HOLD   = 2'd2;
  localparam logic [1:0] REG_WINDOW = 2'd3;

  typedef struct packed {
    logic                double_click_enable;
    logic                active_low;
    logic [PRESS_W-1:0]  hold_limit;
    logic [WINDOW_W-1:0] double_click_window;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } rbuf_stat_t;

endpackage

@@ rtl/bchd_if.sv @@
// ----------------------------------------------------------------------------
// bchd channel interfaces
// sample channel and status channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface bchd_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pin_level;

  modport source (output valid, output mode, output pin_level, input ready);
  modport sink (input valid, input mode, input pin_level, output ready);
endinterface

interface bchd_out_if;
  logic                          valid;
  logic                          ready;
  logic [bchd_pkg::STATUS_W-1:0] button_status;

  modport source (output valid, output button_status, input ready);
  modport sink (input valid, input button_status, output ready);
endinterface

@@ rtl/bchd_cfg.sv @@
// ----------------------------------------------------------------------------
// bchd_cfg
// apb register file holding double click enable, polarity, hold limit and click window
// ----------------------------------------------------------------------------
module bchd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bchd_pkg::PADDR_W-1:0] paddr,
  input  logic [bchd_pkg::PDATA_W-1:0] pwdata,
  output logic [bchd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output bchd_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.double_click_enable <= 1'b0;
      cfg.active_low          <= 1'b1;
      cfg.hold_limit          <= 16'd120;
      cfg.double_click_window <= 8'd40;
    end else if (wr_en) begin
      case (idx)
        bchd_pkg::REG_DCE:    cfg.double_click_enable <= pwdata[0];
        bchd_pkg::REG_ALOW:   cfg.active_low          <= pwdata[0];
        bchd_pkg::REG_HOLD:   cfg.hold_limit          <= pwdata[bchd_pkg::PRESS_W-1:0];
        bchd_pkg::REG_WINDOW: cfg.double_click_window <= pwdata[bchd_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bchd_pkg::REG_DCE:    prdata = {31'd0, cfg.double_click_enable};
      bchd_pkg::REG_ALOW:   prdata = {31'd0, cfg.active_low};
      bchd_pkg::REG_HOLD:   prdata = {16'd0, cfg.hold_limit};
      bchd_pkg::REG_WINDOW: prdata = {24'd0, cfg.double_click_window};
      default:              prdata = '0;
    endcase
  end

endmodule

@@ rtl/bchd_core.sv @@
// ----------------------------------------------------------------------------
// bchd_core
// input register and per-item status update of the press and window counters
// ----------------------------------------------------------------------------
module bchd_core (
  input  logic                 clk,
  input  logic                 rst,
  bchd_in_if.sink              sample,
  input  bchd_pkg::cfg_t       cfg,
  input  bchd_pkg::rbuf_stat_t rb,
  output logic                 push,
  output bchd_pkg::btn_state_t push_status
);

  logic                          stg_vld;
  logic                          stg_mode;
  logic                          stg_pin;
  logic [1:0]                    occ;
  logic                          accept;
  logic                          pressed;

  logic [bchd_pkg::PRESS_W-1:0]  press_ticks;
  logic [bchd_pkg::PRESS_W-1:0]  press_ticks_next;
  logic [bchd_pkg::WINDOW_W-1:0] window_ticks;
  logic [bchd_pkg::WINDOW_W-1:0] window_ticks_next;
  bchd_pkg::btn_state_t          cur_status;
  bchd_pkg::btn_state_t          cur_status_next;
  bchd_pkg::btn_state_t          res;

  // stage plus buffered results never exceed two
  assign occ          = rb.cnt + {1'b0, stg_vld};
  assign sample.ready = (occ != 2'd2) || rb.pop;
  assign accept       = sample.valid && sample.ready;
  assign pressed      = stg_pin ^ cfg.active_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else begin
      stg_vld <= accept;
    end
    if (accept) begin
      stg_mode <= sample.mode;
      stg_pin  <= sample.pin_level;
    end
  end

  always_comb begin
    press_ticks_next  = press_ticks;
    window_ticks_next = window_ticks;
    cur_status_next   = cur_status;
    res               = cur_status;
    if (stg_mode == bchd_pkg::MODE_TICK) begin
      if (pressed) begin
        if (press_ticks != bchd_pkg::PRESS_MAX) begin
          press_ticks_next = press_ticks + 16'd1;
        end
        cur_status_next = (press_ticks_next > cfg.hold_limit) ? bchd_pkg::ST_HELD
                                                              : bchd_pkg::ST_CLOSED;
      end else begin
        if (press_ticks != '0) begin
          if (cur_status == bchd_pkg::ST_HELD) begin
            cur_status_next   = bchd_pkg::ST_RELEASED;
            window_ticks_next = '0;
          end else if (window_ticks > 8'd1) begin
            if (window_ticks < cfg.double_click_window) begin
              cur_status_next   = bchd_pkg::ST_DOUBLE;
              window_ticks_next = '0;
            end
          end else begin
            window_ticks_next = cfg.double_click_enable ? cfg.double_click_window : 8'd1;
          end
        end
        press_ticks_next = '0;
      end
      // window countdown, expiry reports a single click
      if (window_ticks_next != '0) begin
        window_ticks_next = window_ticks_next - 8'd1;
        if (window_ticks_next == '0) begin
          cur_status_next = bchd_pkg::ST_CLICKED;
        end
      end
      res = cur_status_next;
    end else begin
      if (cur_status == bchd_pkg::ST_RELEASED || cur_status == bchd_pkg::ST_CLICKED ||
          cur_status == bchd_pkg::ST_DOUBLE) begin
        cur_status_next = bchd_pkg::ST_OPEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks  <= '0;
      window_ticks <= '0;
      cur_status   <= bchd_pkg::ST_OPEN;
    end else if (stg_vld) begin
      press_ticks  <= press_ticks_next;
      window_ticks <= window_ticks_next;
      cur_status   <= cur_status_next;
    end
  end

  assign push        = stg_vld;
  assign push_status = res;

endmodule

@@ rtl/bchd_rbuf.sv @@
// ----------------------------------------------------------------------------
// bchd_rbuf
// two-word result buffer driving the status channel
// ----------------------------------------------------------------------------
module bchd_rbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bchd_pkg::btn_state_t push_status,
  bchd_out_if.source           status,
  output bchd_pkg::rbuf_stat_t rb
);

  bchd_pkg::btn_state_t slot0;
  bchd_pkg::btn_state_t slot1;
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           cnt;
  logic                 pop;

  assign pop                  = status.valid && status.ready;
  assign status.valid         = (cnt != 2'd0);
  assign status.button_status = rd_ptr ? slot1 : slot0;
  assign rb.cnt               = cnt;
  assign rb.pop               = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
    if (push) begin
      if (wr_ptr) begin
        slot1 <= push_status;
      end else begin
        slot0 <= push_status;
      end
    end
  end

endmodule

@@ rtl/button_click_hold_detector.sv @@
// ----------------------------------------------------------------------------
// button_click_hold_detector
// classifies a sampled button into open, closed, held, released, clicked
// and double clicked
//
//   channel  dir  payload                  handshake
//   sample   in   mode, pin_level          valid/ready
//   status   out  button_status            valid/ready
//   apb      in   double_click_enable,     psel/penable/pwrite, pready
//                 active_low, hold_limit,
//                 double_click_window
//
// one word per cycle unless full, result held in input register then buffer
// state update sits between the input register and the result buffer
// synchronous reset clears counters, status and buffer, loads register defaults
// two-word result buffer absorbs output stalls, sample stalls only when full
// ----------------------------------------------------------------------------
`include "button_click_hold_detector_macros.svh"

module button_click_hold_detector (
  input  logic                         clk,
  input  logic                         rst,
  bchd_in_if.sink                      sample,
  bchd_out_if.source                   status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bchd_pkg::PADDR_W-1:0] paddr,
  input  logic [bchd_pkg::PDATA_W-1:0] pwdata,
  output logic [bchd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  bchd_pkg::cfg_t       cfg;
  bchd_pkg::rbuf_stat_t rb;
  logic                 push;
  bchd_pkg::btn_state_t push_status;

  bchd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bchd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .cfg         (cfg),
    .rb          (rb),
    .push        (push),
    .push_status (push_status)
  );

  bchd_rbuf u_rbuf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_status (push_status),
    .status      (status),
    .rb          (rb)
  );

  `BCHD_ASSERT_NXT(a_hold_write, clk, rst, psel && penable && pwrite && paddr[3:2] == bchd_pkg::REG_HOLD, cfg.hold_limit == $past(pwdata[bchd_pkg::PRESS_W-1:0]), "hold limit write lost")
  `BCHD_ASSERT_LAT2(a_result_latency, clk, rst, sample.valid && sample.ready, status.valid, "result missing two cycles after sample")
  `BCHD_ASSERT_IMP(a_stall_cause, clk, rst, !sample.ready, status.valid && !status.ready, "sample stalled without output backpressure")

endmodule

@@ test/button_click_hold_detector_tb.sv @@
// ----------------------------------------------------------------------------
// button_click_hold_detector_tb
// drives pin samples and status reads through the sample channel, predicts
// every status word from a behavioral copy of the detector and compares it
// with the status channel; covers polarity, hold limits, click windows and
// the top of the hold limit range, partly under random stalls on both channels
// ----------------------------------------------------------------------------
module button_click_hold_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_WORDS  = 190;
  localparam int RANDOM_SETS  = 9;
  localparam int MAX_REPORTS  = 10;

  class status_scoreboard;
    logic                          dce;
    logic                          alow;
    logic [bchd_pkg::PRESS_W-1:0]  hold;
    logic [bchd_pkg::WINDOW_W-1:0] window;
    logic [bchd_pkg::PRESS_W-1:0]  press_cnt;
    logic [bchd_pkg::WINDOW_W-1:0] win_cnt;
    bchd_pkg::btn_state_t          cur;
    bchd_pkg::btn_state_t          expected_q[$];
    int                            errors;
    int                            checked;

    function new();
      dce       = 1'b0;
      alow      = 1'b1;
      hold      = 16'd120;
      window    = 8'd40;
      press_cnt = '0;
      win_cnt   = '0;
      cur       = bchd_pkg::ST_OPEN;
      errors    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [bchd_pkg::PDATA_W-1:0] val);
      case (idx)
        bchd_pkg::REG_DCE:    dce    = val[0];
        bchd_pkg::REG_ALOW:   alow   = val[0];
        bchd_pkg::REG_HOLD:   hold   = val[bchd_pkg::PRESS_W-1:0];
        bchd_pkg::REG_WINDOW: window = val[bchd_pkg::WINDOW_W-1:0];
        default:    ;
      endcase
    endfunction

    function void note_word(logic mode, logic pin);
      logic pressed;
      pressed = pin ^ alow;
      if (mode == bchd_pkg::MODE_READ) begin
        expected_q.push_back(cur);
        if (cur == bchd_pkg::ST_RELEASED || cur == bchd_pkg::ST_CLICKED ||
            cur == bchd_pkg::ST_DOUBLE) cur = bchd_pkg::ST_OPEN;
        return;
      end
      if (pressed) begin
        if (press_cnt != bchd_pkg::PRESS_MAX) press_cnt = press_cnt + 1'b1;
        cur = (press_cnt > hold) ? bchd_pkg::ST_HELD : bchd_pkg::ST_CLOSED;
      end else begin
        if (press_cnt != 0) begin
          if (cur == bchd_pkg::ST_HELD) begin
            cur     = bchd_pkg::ST_RELEASED;
            win_cnt = '0;
          end else if (win_cnt > 1) begin
            if (win_cnt < window) begin
              cur     = bchd_pkg::ST_DOUBLE;
              win_cnt = '0;
            end
          end else begin
            win_cnt = dce ? window : 8'd1;
          end
        end
        press_cnt = '0;
      end
      if (win_cnt != 0) begin
        win_cnt = win_cnt - 1'b1;
        if (win_cnt == 0) cur = bchd_pkg::ST_CLICKED;
      end
      expected_q.push_back(cur);
    endfunction

    function void check_status(logic [bchd_pkg::STATUS_W-1:0] got);
      bchd_pkg::btn_state_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("status word %0d with no word pending", got);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got !== exp) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("status mismatch at word %0d: expected %0d, got %0d", checked, exp, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bchd_pkg::PADDR_W-1:0]  paddr;
  logic [bchd_pkg::PDATA_W-1:0]  pwdata;
  logic [bchd_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  bchd_in_if  sample_ch ();
  bchd_out_if status_ch ();

  button_click_hold_detector i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  status_scoreboard sb = new();

  int tx_idle_pct = 17;
  int rx_idle_pct = 78;
  int ticks_sent  = 0;
  int reads_sent  = 0;
  int settings    = 0;
  int cycle_cnt   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    status_ch.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (status_ch.valid && status_ch.ready) sb.check_status(status_ch.button_status);
      if (sample_ch.valid && sample_ch.ready) sb.note_word(sample_ch.mode, sample_ch.pin_level);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d words pending", cycle_cnt, sb.pending());
    $display("FAIL button_click_hold_detector");
    $finish;
  end

  task automatic send_word(logic mode, logic pin);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.mode      <= mode;
    sample_ch.pin_level <= pin;
    do @(posedge clk); while (!sample_ch.ready);
    if (mode == bchd_pkg::MODE_READ) reads_sent++;
    else ticks_sent++;
  endtask

  // pin level that the current polarity reads as pressed or not
  task automatic tick(logic pressed_key);
    if ($urandom_range(99) < 12) send_word(bchd_pkg::MODE_READ, 1'($urandom_range(1)));
    send_word(bchd_pkg::MODE_TICK, pressed_key ^ sb.alow);
  endtask

  task automatic wait_results();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [bchd_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic dce, logic alow, int hold, int window);
    apb_write(bchd_pkg::REG_DCE, bchd_pkg::PDATA_W'(dce));
    apb_write(bchd_pkg::REG_ALOW, bchd_pkg::PDATA_W'(alow));
    apb_write(bchd_pkg::REG_HOLD, hold);
    apb_write(bchd_pkg::REG_WINDOW, window);
    settings++;
  endtask

  task automatic click_sequence();
    int clicks;
    int press_len;
    int gap_len;
    int hold_cap;
    int win_cap;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) begin
        send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end else begin
      clicks   = $urandom_range(1, 2);
      hold_cap = (sb.hold > 20) ? 20 : sb.hold;
      win_cap  = (sb.window > 30) ? 30 : sb.window;
      repeat (clicks) begin
        press_len = $urandom_range(1, hold_cap + 3);
        gap_len   = $urandom_range(1, win_cap + 3);
        repeat (press_len) tick(1'b1);
        repeat (gap_len) tick(1'b0);
      end
      if ($urandom_range(1)) send_word(bchd_pkg::MODE_READ, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int dce_set[RANDOM_SETS]    = '{1, 0, 1, 1, 0, 1, 1, 0, 1};
    int alow_set[RANDOM_SETS]   = '{1, 0, 0, 1, 1, 0, 1, 0, 1};
    int hold_set[RANDOM_SETS]   = '{5, 3, 8, 1, 10, 2, 4, 65534, 6};
    int window_set[RANDOM_SETS] = '{12, 2, 255, 2, 20, 0, 1, 6, 9};
    int start;

    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.mode      <= bchd_pkg::MODE_TICK;
    sample_ch.pin_level <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: single click reported at once
    send_word(bchd_pkg::MODE_READ, 1'b0);
    send_word(bchd_pkg::MODE_TICK, 1'b1);
    send_word(bchd_pkg::MODE_TICK, 1'b0);
    send_word(bchd_pkg::MODE_TICK, 1'b1);
    send_word(bchd_pkg::MODE_READ, 1'b1);
    send_word(bchd_pkg::MODE_READ, 1'b0);
    wait_results();

    // held then released
    set_config(1'b0, 1'b1, 2, 3);
    repeat (3) send_word(bchd_pkg::MODE_TICK, 1'b0);
    send_word(bchd_pkg::MODE_READ, 1'b0);
    send_word(bchd_pkg::MODE_TICK, 1'b1);
    send_word(bchd_pkg::MODE_READ, 1'b1);
    wait_results();

    // active high, two quick clicks without a double, then a single click
    set_config(1'b1, 1'b0, 2, 3);
    send_word(bchd_pkg::MODE_TICK, 1'b1);
    send_word(bchd_pkg::MODE_TICK, 1'b0);
    send_word(bchd_pkg::MODE_TICK, 1'b1);
    send_word(bchd_pkg::MODE_TICK, 1'b0);
    send_word(bchd_pkg::MODE_READ, 1'b0);
    send_word(bchd_pkg::MODE_TICK, 1'b1);
    repeat (3) send_word(bchd_pkg::MODE_TICK, 1'b0);
    send_word(bchd_pkg::MODE_READ, 1'b1);
    wait_results();

    for (int p = 0; p < RANDOM_SETS; p++) begin
      case (p / 3)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      set_config(1'(dce_set[p]), 1'(alow_set[p]), hold_set[p], window_set[p]);
      start = ticks_sent + reads_sent;
      while (ticks_sent + reads_sent - start < PHASE_WORDS) begin
        click_sequence();
        if (p == 1 && ticks_sent + reads_sent - start >= PHASE_WORDS / 2 &&
            sb.pending() != 0) begin
          wait_results();
        end
      end
      wait_results();
    end

    // hold limit at the top of the range, never reached
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(1'b1, 1'b1, 65535, 255);
    repeat (40) send_word(bchd_pkg::MODE_TICK, 1'b0);
    repeat (3) send_word(bchd_pkg::MODE_TICK, 1'b1);
    send_word(bchd_pkg::MODE_READ, 1'b0);
    wait_results();
    repeat (8) @(posedge clk);

    $display("ran %0d ticks and %0d status reads over %0d register settings",
             ticks_sent, reads_sent, settings);
    $display("checked %0d status words, %0d failures", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS button_click_hold_detector");
    end else begin
      $display("FAIL button_click_hold_detector");
    end
    $finish;
  end

endmodule
